@@ rtl/core/floor_texture_coord_generator_core_macros.svh @@
// Assertion macros shared by the floor texture coordinate generator RTL.
`ifndef FLOOR_TEXTURE_COORD_GENERATOR_CORE_MACROS_SVH
`define FLOOR_TEXTURE_COORD_GENERATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define FCG_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fcg: same-cycle check failed");
// next-cycle implication
`define FCG_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fcg: next-cycle check failed");
`else
`define FCG_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define FCG_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/fcg_pkg.sv @@
// Package: constants, types and helpers of the floor texture coordinate generator.
`default_nettype none

package fcg_pkg;

	// screen and texture geometry; the screen width must be a power of two
	localparam int SCREEN_WIDTH_LOG2 = 10;
	localparam int SCREEN_HEIGHT     = 768;
	localparam int TEX_WIDTH_LOG2    = 6;
	localparam int TEX_HEIGHT_LOG2   = 6;
	localparam int FRAC_BITS         = 16;
	localparam int HALF_H            = SCREEN_HEIGHT / 2;

	// field widths
	localparam int POS_W   = 32;
	localparam int DIR_W   = 19;
	localparam int SHIFT_W = 10;
	localparam int FOG_W   = 32;
	localparam int ROW_W   = 10;
	localparam int TEXEL_W = 6;
	localparam int COORD_W = 32;
	localparam int DIST_W  = 32;

	// configuration port
	localparam int DATA_W    = 32;
	localparam int PADDR_W   = 5;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_POSITION_X   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_POSITION_Y   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DIRECTION_X  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DIRECTION_Y  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_PLANE_X      = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_PLANE_Y      = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_HORIZON_SHIFT = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_FOG_SCALE    = 3'd7;

	// register reset values
	localparam logic signed [DIR_W-1:0] DIRECTION_X_RST = 19'sd65536;
	localparam logic signed [DIR_W-1:0] PLANE_Y_RST     = 19'sd43253;

	// horizon arithmetic: signed width that holds row - horizon for any input
	localparam int HOR_W  = $clog2(HALF_H + 1536) + 1;
	localparam int OFFS_W = HOR_W - 1;

	// row distance divider: numerator HALF_H << FRAC_BITS
	localparam int DIV_NUM_W = $clog2(HALF_H) + FRAC_BITS + 1;
	localparam logic [DIV_NUM_W-1:0] DIV_NUM = DIV_NUM_W'(HALF_H) << FRAC_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);
	localparam int DQ_W      = (DIV_NUM_W > DIST_W) ? DIV_NUM_W : DIST_W + 1;

	// shared multiplier: unsigned distance times signed operand
	localparam int MUL_B_W    = DIST_W + 1;
	localparam int PROD_W     = 2 * MUL_B_W;
	localparam int STEP_SHIFT = FRAC_BITS + SCREEN_WIDTH_LOG2;

	// divider request and response
	typedef struct packed {
		logic              start;
		logic [OFFS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [DIV_NUM_W-1:0] quotient;
	} div_rsp_t;

	// quotient clamped to the 32-bit distance range
	function automatic logic [DIST_W-1:0] dist_sat(input logic [DIV_NUM_W-1:0] q);
		logic [DQ_W-1:0] w;
		w = DQ_W'(q);
		return (w[DQ_W-1:DIST_W] != '0) ? '1 : w[DIST_W-1:0];
	endfunction

	// texel index from the fraction of a world coordinate
	function automatic logic [TEXEL_W-1:0] texel(input logic [COORD_W-1:0] coord,
			input int tlog2);
		logic [COORD_W-1:0] v;
		if (tlog2 <= FRAC_BITS) begin
			v = coord >> (FRAC_BITS - tlog2);
		end else begin
			v = coord << (tlog2 - FRAC_BITS);
		end
		v = v & ((COORD_W'(1) << tlog2) - COORD_W'(1));
		return v[TEXEL_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/fcg_div.sv @@
// Restoring divider, one quotient bit per cycle, for the row distance.
`default_nettype none

`include "floor_texture_coord_generator_core_macros.svh"

module fcg_div
	import fcg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [OFFS_W-1:0]    rem_q;
	logic [OFFS_W-1:0]    div_q;

	// trial subtract of the shifted remainder
	logic [OFFS_W:0] trial;
	logic [OFFS_W:0] diff;
	logic            fits;

	assign trial = {rem_q, num_q[DIV_NUM_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= DIV_NUM;
			rem_q <= '0;
			quo_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= fits ? diff[OFFS_W-1:0] : trial[OFFS_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	`FCG_ASSERT_IMPL(a_start_idle, clk, arst_n, req.start, !busy_q)
	`FCG_ASSERT_IMPL(a_divisor_nonzero, clk, arst_n, req.start, req.divisor != '0)
	`FCG_ASSERT_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q)
	`FCG_ASSERT_IMPL(a_rem_below_divisor, clk, arst_n, busy_q, rem_q < div_q)

endmodule

`default_nettype wire

@@ rtl/core/fcg_mul.sv @@
// Shared registered multiplier: unsigned distance times a signed operand.
`default_nettype none

module fcg_mul
	import fcg_pkg::*;
(
	input  logic                      clk,
	input  logic                      en,
	input  logic [DIST_W-1:0]         a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [PROD_W-1:0]  prod_q
);

	logic signed [DIST_W:0]   a_s;
	logic signed [PROD_W-1:0] prod;

	assign a_s  = $signed({1'b0, a});
	assign prod = a_s * b;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= prod;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/floor_texture_coord_generator_core.sv @@
// Top level: floor and ceiling texture coordinate generator for a raycaster.
`default_nettype none

`include "floor_texture_coord_generator_core_macros.svh"

// Takes one pixel per transfer in raster order and returns one texel result per
// pixel (texture column and row, floor or ceiling, fog, horizon flag). A pixel
// without row_start is registered to the output; a row_start pixel runs the row
// setup first: a serial divider forms the row distance at one quotient bit per
// cycle, then one shared multiplier forms the fog, both steps and both world
// start coordinates, each in a multiply and a write-back state (no divide on
// the horizon row). Row setup time is set by the divider loop and the shared
// multiplier. Positions, distances, fog and coordinates are Q16.16; the world
// coordinate advances by the step after each pixel. Configuration must be
// written over the APB-style port while the block is idle; nothing enforces it.
module floor_texture_coord_generator_core
	import fcg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// pixel in
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [ROW_W-1:0]   row,
	input  logic               row_start,
	// texel out
	output logic               out_valid,
	input  logic               out_ready,
	output logic [TEXEL_W-1:0] texel_u,
	output logic [TEXEL_W-1:0] texel_v,
	output logic               floor_side,
	output logic [FOG_W-1:0]   fog_amount,
	output logic               horizon_hit,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_WB,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		OP_FOG,
		OP_STEP_X,
		OP_STEP_Y,
		OP_WORLD_X,
		OP_WORLD_Y
	} op_t;

	// configuration registers
	logic signed [POS_W-1:0]   position_x_q;
	logic signed [POS_W-1:0]   position_y_q;
	logic signed [DIR_W-1:0]   direction_x_q;
	logic signed [DIR_W-1:0]   direction_y_q;
	logic signed [DIR_W-1:0]   plane_x_q;
	logic signed [DIR_W-1:0]   plane_y_q;
	logic signed [SHIFT_W-1:0] horizon_shift_q;
	logic [FOG_W-1:0]          fog_scale_q;

	// sequencer and row state
	state_t             state_q;
	op_t                op_q;
	logic [DIST_W-1:0]  dist_q;
	logic [COORD_W-1:0] world_x_q;
	logic [COORD_W-1:0] world_y_q;
	logic [COORD_W-1:0] step_x_q;
	logic [COORD_W-1:0] step_y_q;
	logic               row_is_floor_q;
	logic [FOG_W-1:0]   row_fog_q;
	logic               row_sat_q;

	// output register
	logic               out_valid_q;
	logic [TEXEL_W-1:0] texel_u_q;
	logic [TEXEL_W-1:0] texel_v_q;
	logic               floor_side_q;
	logic [FOG_W-1:0]   fog_amount_q;
	logic               horizon_hit_q;

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;
	logic                 accept;
	logic                 emit;

	logic signed [HOR_W-1:0] horizon;
	logic signed [HOR_W-1:0] row_s;
	logic signed [HOR_W-1:0] row_diff;
	logic signed [HOR_W-1:0] offs_abs;
	logic [OFFS_W-1:0]       offs;
	logic                    new_floor;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [PROD_W-1:0]  prod_frac;
	logic signed [PROD_W-1:0]  prod_step;
	logic                      fog_ovf;

	// configuration write and read
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_x_q    <= '0;
			position_y_q    <= '0;
			direction_x_q   <= DIRECTION_X_RST;
			direction_y_q   <= '0;
			plane_x_q       <= '0;
			plane_y_q       <= PLANE_Y_RST;
			horizon_shift_q <= '0;
			fog_scale_q     <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_POSITION_X:    position_x_q    <= $signed(pwdata[POS_W-1:0]);
				REG_POSITION_Y:    position_y_q    <= $signed(pwdata[POS_W-1:0]);
				REG_DIRECTION_X:   direction_x_q   <= $signed(pwdata[DIR_W-1:0]);
				REG_DIRECTION_Y:   direction_y_q   <= $signed(pwdata[DIR_W-1:0]);
				REG_PLANE_X:       plane_x_q       <= $signed(pwdata[DIR_W-1:0]);
				REG_PLANE_Y:       plane_y_q       <= $signed(pwdata[DIR_W-1:0]);
				REG_HORIZON_SHIFT: horizon_shift_q <= $signed(pwdata[SHIFT_W-1:0]);
				REG_FOG_SCALE:     fog_scale_q     <= pwdata[FOG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_POSITION_X:    prdata = DATA_W'($unsigned(position_x_q));
			REG_POSITION_Y:    prdata = DATA_W'($unsigned(position_y_q));
			REG_DIRECTION_X:   prdata = DATA_W'($unsigned(direction_x_q));
			REG_DIRECTION_Y:   prdata = DATA_W'($unsigned(direction_y_q));
			REG_PLANE_X:       prdata = DATA_W'($unsigned(plane_x_q));
			REG_PLANE_Y:       prdata = DATA_W'($unsigned(plane_y_q));
			REG_HORIZON_SHIFT: prdata = DATA_W'($unsigned(horizon_shift_q));
			REG_FOG_SCALE:     prdata = DATA_W'(fog_scale_q);
			default:           prdata = '0;
		endcase
	end

	// handshake
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign emit     = (accept && !row_start) || (state_q == ST_EMIT);

	// floor decision and row offset against the shifted horizon
	assign horizon   = HOR_W'(HALF_H) + HOR_W'(horizon_shift_q);
	assign row_s     = $signed(HOR_W'(row));
	assign new_floor = row_s > horizon;
	assign row_diff  = row_s - horizon;
	assign offs_abs  = new_floor ? row_diff : -row_diff;
	assign offs      = offs_abs[OFFS_W-1:0];

	// row distance divider
	assign div_req.start   = accept && row_start && (offs != '0);
	assign div_req.divisor = offs;

	fcg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// multiplier operand per setup step
	always_comb begin
		unique case (op_q)
			OP_FOG:     mul_b = $signed({1'b0, fog_scale_q});
			OP_STEP_X:  mul_b = MUL_B_W'(plane_x_q) <<< 1;
			OP_STEP_Y:  mul_b = MUL_B_W'(plane_y_q) <<< 1;
			OP_WORLD_X: mul_b = MUL_B_W'(direction_x_q) - MUL_B_W'(plane_x_q);
			OP_WORLD_Y: mul_b = MUL_B_W'(direction_y_q) - MUL_B_W'(plane_y_q);
			default:    mul_b = '0;
		endcase
	end

	fcg_mul u_mul (
		.clk    (clk),
		.en     (state_q == ST_MUL),
		.a      (dist_q),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// floor-rounded scaling of the product
	assign prod_frac = prod_q >>> FRAC_BITS;
	assign prod_step = prod_q >>> STEP_SHIFT;
	assign fog_ovf   = prod_q[PROD_W-1:FRAC_BITS+FOG_W] != '0;

	// sequencer, row state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			op_q           <= OP_FOG;
			dist_q         <= '0;
			world_x_q      <= '0;
			world_y_q      <= '0;
			step_x_q       <= '0;
			step_y_q       <= '0;
			row_is_floor_q <= 1'b0;
			row_fog_q      <= '0;
			row_sat_q      <= 1'b0;
			out_valid_q    <= 1'b0;
			texel_u_q      <= '0;
			texel_v_q      <= '0;
			floor_side_q   <= 1'b0;
			fog_amount_q   <= '0;
			horizon_hit_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept && row_start) begin
						row_is_floor_q <= new_floor;
						op_q           <= OP_FOG;
						if (offs == '0) begin
							// horizon row: distance saturates, no divide
							dist_q    <= '1;
							row_sat_q <= 1'b1;
							state_q   <= ST_MUL;
						end else begin
							row_sat_q <= 1'b0;
							state_q   <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						dist_q  <= dist_sat(div_rsp.quotient);
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					state_q <= ST_MUL;
					unique case (op_q)
						OP_FOG: begin
							row_fog_q <= fog_ovf ? '1 : prod_frac[FOG_W-1:0];
							op_q      <= OP_STEP_X;
						end
						OP_STEP_X: begin
							step_x_q <= prod_step[COORD_W-1:0];
							op_q     <= OP_STEP_Y;
						end
						OP_STEP_Y: begin
							step_y_q <= prod_step[COORD_W-1:0];
							op_q     <= OP_WORLD_X;
						end
						OP_WORLD_X: begin
							world_x_q <= prod_frac[COORD_W-1:0] + $unsigned(position_x_q);
							op_q      <= OP_WORLD_Y;
						end
						OP_WORLD_Y: begin
							world_y_q <= prod_frac[COORD_W-1:0] + $unsigned(position_y_q);
							op_q      <= OP_FOG;
							state_q   <= ST_EMIT;
						end
						default: begin
							op_q    <= OP_FOG;
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_EMIT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// load the result and step the world coordinate
			if (emit) begin
				out_valid_q   <= 1'b1;
				texel_u_q     <= texel(world_x_q, TEX_WIDTH_LOG2);
				texel_v_q     <= texel(world_y_q, TEX_HEIGHT_LOG2);
				floor_side_q  <= row_is_floor_q;
				fog_amount_q  <= row_fog_q;
				horizon_hit_q <= row_sat_q;
				world_x_q     <= world_x_q + step_x_q;
				world_y_q     <= world_y_q + step_y_q;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign texel_u     = texel_u_q;
	assign texel_v     = texel_v_q;
	assign floor_side  = floor_side_q;
	assign fog_amount  = fog_amount_q;
	assign horizon_hit = horizon_hit_q;

	`FCG_ASSERT_IMPL(a_emit_slot_free, clk, arst_n, state_q == ST_EMIT, !out_valid_q)
	`FCG_ASSERT_NEXT(a_div_to_mul, clk, arst_n, (state_q == ST_DIV) && div_rsp.done,
		(state_q == ST_MUL) && (op_q == OP_FOG))
	`FCG_ASSERT_NEXT(a_pixel_one_cycle, clk, arst_n, accept && !row_start, out_valid_q)
	`FCG_ASSERT_IMPL(a_horizon_dist, clk, arst_n, row_sat_q && (state_q == ST_MUL), dist_q == '1)

endmodule

`default_nettype wire

@@ verif/fcg_texel_checker.sv @@
`timescale 1ns / 1ps
// Checker for the floor texture coordinate generator: predicts each texel result and compares.
module fcg_texel_checker
	import fcg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// pixel channel
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [ROW_W-1:0]   row,
	input  logic               row_start,
	// texel channel
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [TEXEL_W-1:0] texel_u,
	input  logic [TEXEL_W-1:0] texel_v,
	input  logic               floor_side,
	input  logic [FOG_W-1:0]   fog_amount,
	input  logic               horizon_hit,
	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	input  logic               pready,
	// status to the top
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic [TEXEL_W-1:0] u;
		logic [TEXEL_W-1:0] v;
		logic               floor_side;
		logic [FOG_W-1:0]   fog;
		logic               hit;
	} texel_t;

	// shadow copies of the registers
	logic signed [POS_W-1:0]   pos_x, pos_y;
	logic signed [DIR_W-1:0]   dir_x, dir_y, pln_x, pln_y;
	logic signed [SHIFT_W-1:0] hshift;
	logic [FOG_W-1:0]          fog_k;

	// per-row walk state
	logic [COORD_W-1:0] world_x, world_y, step_x, step_y;
	logic [FOG_W-1:0]   row_fog;
	logic               row_floor, row_hit;

	texel_t texel_q[$];
	int     fails;
	int     reported;

	// row setup: side, distance, fog, start coordinate and per-pixel step
	function automatic void setup_row(input logic [ROW_W-1:0] r);
		longint      horizon, offs, row_dist, r0x, r0y, dpx, dpy;
		logic [63:0] fog_p;
		horizon   = longint'(HALF_H) + longint'(hshift);
		row_floor = longint'(r) > horizon;
		offs      = row_floor ? longint'(r) - horizon : horizon - longint'(r);
		row_hit   = (offs == 0);
		if (row_hit) begin
			row_dist = longint'(32'hFFFF_FFFF);
		end else begin
			row_dist = (longint'(HALF_H) <<< FRAC_BITS) / offs;
		end
		fog_p   = (64'(row_dist) * {32'b0, fog_k}) >> FRAC_BITS;
		row_fog = (fog_p[63:32] != '0) ? '1 : fog_p[31:0];
		// leftmost ray is dir - plane; rightmost minus leftmost is twice the plane
		r0x = longint'(dir_x) - longint'(pln_x);
		r0y = longint'(dir_y) - longint'(pln_y);
		dpx = 2 * longint'(pln_x);
		dpy = 2 * longint'(pln_y);
		// power-of-two divisors: arithmetic shift is a floor division
		step_x  = COORD_W'((row_dist * dpx) >>> (FRAC_BITS + SCREEN_WIDTH_LOG2));
		step_y  = COORD_W'((row_dist * dpy) >>> (FRAC_BITS + SCREEN_WIDTH_LOG2));
		world_x = COORD_W'((row_dist * r0x) >>> FRAC_BITS) + COORD_W'(pos_x);
		world_y = COORD_W'((row_dist * r0y) >>> FRAC_BITS) + COORD_W'(pos_y);
	endfunction

	// texel for one pixel, then step the world coordinate
	function automatic texel_t next_texel(input logic [ROW_W-1:0] r, input logic s);
		texel_t t;
		if (s) begin
			setup_row(r);
		end
		t.u          = TEXEL_W'(world_x >> (FRAC_BITS - TEX_WIDTH_LOG2));
		t.v          = TEXEL_W'(world_y >> (FRAC_BITS - TEX_HEIGHT_LOG2));
		t.floor_side = row_floor;
		t.fog        = row_fog;
		t.hit        = row_hit;
		world_x      = world_x + step_x;
		world_y      = world_y + step_y;
		return t;
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			fails++;
			if (reported < 100) begin
				reported++;
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		texel_t want;
		if (!arst_n) begin
			pos_x     = '0;
			pos_y     = '0;
			dir_x     = DIRECTION_X_RST;
			dir_y     = '0;
			pln_x     = '0;
			pln_y     = PLANE_Y_RST;
			hshift    = '0;
			fog_k     = '0;
			world_x   = '0;
			world_y   = '0;
			step_x    = '0;
			step_y    = '0;
			row_fog   = '0;
			row_floor = 1'b0;
			row_hit   = 1'b0;
			texel_q.delete();
			fails     = 0;
			reported  = 0;
			errors    <= 0;
			pending   <= 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[2 +: REG_IDX_W])
					REG_POSITION_X:    pos_x  = pwdata[POS_W-1:0];
					REG_POSITION_Y:    pos_y  = pwdata[POS_W-1:0];
					REG_DIRECTION_X:   dir_x  = pwdata[DIR_W-1:0];
					REG_DIRECTION_Y:   dir_y  = pwdata[DIR_W-1:0];
					REG_PLANE_X:       pln_x  = pwdata[DIR_W-1:0];
					REG_PLANE_Y:       pln_y  = pwdata[DIR_W-1:0];
					REG_HORIZON_SHIFT: hshift = pwdata[SHIFT_W-1:0];
					REG_FOG_SCALE:     fog_k  = pwdata[FOG_W-1:0];
					default: ;
				endcase
			end
			// pixel transfer: queue its expected texel
			if (in_valid && in_ready) begin
				texel_q.push_back(next_texel(row, row_start));
			end
			// texel transfer: compare with the oldest expectation
			if (out_valid && out_ready) begin
				if (texel_q.size() == 0) begin
					fails++;
					if (reported < 100) begin
						reported++;
						$display(
							"%0t: texel transfer with none expected, expected none actual %0d %0d",
							$time, texel_u, texel_v);
					end
				end else begin
					want = texel_q.pop_front();
					check_field("texel_u", want.u, texel_u);
					check_field("texel_v", want.v, texel_v);
					check_field("floor_side", want.floor_side, floor_side);
					check_field("fog_amount", want.fog, fog_amount);
					check_field("horizon_hit", want.hit, horizon_hit);
				end
			end
			errors  <= fails;
			pending <= texel_q.size();
		end
	end

endmodule

@@ verif/tb_floor_texture_coord_generator_core.sv @@
`timescale 1ns / 1ps
// Testbench top: pixel stimulus, register setup and verdict for the texture coordinate generator.
module tb_floor_texture_coord_generator_core;
	import fcg_pkg::*;

	localparam int ROWS_PER_PHASE = 12;
	localparam int NUM_PHASES     = 8;
	localparam int ROW_MAX        = (1 << ROW_W) - 1;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid, in_ready;
	logic [ROW_W-1:0]   row;
	logic               row_start;
	logic               out_valid, out_ready;
	logic [TEXEL_W-1:0] texel_u, texel_v;
	logic               floor_side, horizon_hit;
	logic [FOG_W-1:0]   fog_amount;
	logic               psel, penable, pwrite, pready;
	logic [PADDR_W-1:0] paddr;
	logic [DATA_W-1:0]  pwdata, prdata;

	int   errors, pending;
	logic quiet = 1'b0;
	int   cur_shift = 0;

	always #5 clk = ~clk;

	floor_texture_coord_generator_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.row         (row),
		.row_start   (row_start),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.texel_u     (texel_u),
		.texel_v     (texel_v),
		.floor_side  (floor_side),
		.fog_amount  (fog_amount),
		.horizon_hit (horizon_hit),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	fcg_texel_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.row         (row),
		.row_start   (row_start),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.texel_u     (texel_u),
		.texel_v     (texel_v),
		.floor_side  (floor_side),
		.fog_amount  (fog_amount),
		.horizon_hit (horizon_hit),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.errors      (errors),
		.pending     (pending)
	);

	// one pixel transfer, after a random gap unless idling is off
	task automatic send_pixel(input logic [ROW_W-1:0] r, input logic s);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		row       <= r;
		row_start <= s;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop sending and wait for every expected texel
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// setup phase, then access phase, then psel and penable dropped
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// rows near the horizon are favored, the horizon row itself often
	function automatic logic [ROW_W-1:0] pick_row(input int hor);
		int sel, r;
		sel = $urandom_range(0, 7);
		if (sel < 2) begin
			r = hor;
		end else if (sel < 4) begin
			r = hor + int'($urandom_range(0, 6)) - 3;
		end else begin
			r = $urandom_range(0, ROW_MAX);
		end
		if (r < 0 || r > ROW_MAX) begin
			r = $urandom_range(0, ROW_MAX);
		end
		return ROW_W'(r);
	endfunction

	// texel sink with random stalls
	initial begin : sink
		int stall;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 3);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	initial begin : stim
		logic [DATA_W-1:0] cfg [8];
		int n, len, hor;
		in_valid  <= 1'b0;
		row       <= '0;
		row_start <= 1'b0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: pixels before any row setup, then horizon, extremes and neighbors
		send_pixel(ROW_W'(ROW_MAX), 1'b0);
		send_pixel(ROW_W'(0), 1'b0);
		send_pixel(ROW_W'(682), 1'b0);
		send_pixel(ROW_W'(HALF_H), 1'b1);
		send_pixel(ROW_W'(341), 1'b0);
		send_pixel(ROW_W'(0), 1'b1);
		send_pixel(ROW_W'(ROW_MAX), 1'b0);
		send_pixel(ROW_W'(ROW_MAX), 1'b1);
		send_pixel(ROW_W'(0), 1'b0);
		send_pixel(ROW_W'(HALF_H - 1), 1'b1);
		send_pixel(ROW_W'(HALF_H + 1), 1'b1);
		send_pixel(ROW_W'(SCREEN_HEIGHT - 1), 1'b1);
		send_pixel(ROW_W'(0), 1'b0);
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin
					cfg[REG_POSITION_X]    = 32'h7FFF_FFFF;
					cfg[REG_POSITION_Y]    = 32'h7FFF_FFFF;
					cfg[REG_DIRECTION_X]   = DATA_W'(131072);
					cfg[REG_DIRECTION_Y]   = DATA_W'(131072);
					cfg[REG_PLANE_X]       = DATA_W'(131072);
					cfg[REG_PLANE_Y]       = DATA_W'(131072);
					cfg[REG_HORIZON_SHIFT] = DATA_W'(384);
					cfg[REG_FOG_SCALE]     = 32'hFFFF_FFFF;
				end
				1: begin
					cfg[REG_POSITION_X]    = 32'h8000_0000;
					cfg[REG_POSITION_Y]    = 32'h8000_0000;
					cfg[REG_DIRECTION_X]   = DATA_W'(-131072);
					cfg[REG_DIRECTION_Y]   = DATA_W'(-131072);
					cfg[REG_PLANE_X]       = DATA_W'(-131072);
					cfg[REG_PLANE_Y]       = DATA_W'(-131072);
					cfg[REG_HORIZON_SHIFT] = DATA_W'(-384);
					cfg[REG_FOG_SCALE]     = '0;
				end
				default: begin
					cfg[REG_POSITION_X]    = $urandom();
					cfg[REG_POSITION_Y]    = $urandom();
					cfg[REG_DIRECTION_X]   = DATA_W'(int'($urandom_range(0, 262144)) - 131072);
					cfg[REG_DIRECTION_Y]   = DATA_W'(int'($urandom_range(0, 262144)) - 131072);
					cfg[REG_PLANE_X]       = DATA_W'(int'($urandom_range(0, 262144)) - 131072);
					cfg[REG_PLANE_Y]       = DATA_W'(int'($urandom_range(0, 262144)) - 131072);
					cfg[REG_HORIZON_SHIFT] = DATA_W'(int'($urandom_range(0, 768)) - 384);
					case ($urandom_range(0, 3))
						0: cfg[REG_FOG_SCALE] = $urandom();
						1: cfg[REG_FOG_SCALE] = $urandom_range(0, 4 << FRAC_BITS);
						2: cfg[REG_FOG_SCALE] = $urandom_range(0, 255);
						default: cfg[REG_FOG_SCALE] = 32'hFFFF_FFFF;
					endcase
				end
			endcase
			for (int i = 0; i < 8; i++) begin
				write_reg(REG_IDX_W'(i), cfg[i]);
			end
			cur_shift = int'($signed(cfg[REG_HORIZON_SHIFT][SHIFT_W-1:0]));
			hor       = HALF_H + cur_shift;
			quiet     = (p == 2 || p == 5);

			// one row longer than the screen: the walk just keeps stepping
			if (p == 3) begin
				send_pixel(pick_row(hor), 1'b1);
				repeat ((1 << SCREEN_WIDTH_LOG2) + 6) begin
					send_pixel(ROW_W'($urandom_range(0, ROW_MAX)), 1'b0);
				end
			end

			// mostly short rows, now and then a longer one
			n = 0;
			while (n < ROWS_PER_PHASE) begin
				len = ($urandom_range(0, 9) == 0) ?
					$urandom_range(9, 40) : $urandom_range(1, 6);
				send_pixel(pick_row(hor), 1'b1);
				n++;
				repeat (len - 1) begin
					send_pixel(ROW_W'($urandom_range(0, ROW_MAX)), 1'b0);
					n++;
				end
			end
			drain();
		end

		repeat (60) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin : watchdog
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
